FILE: rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text converter
// Character codes, digit limits and the divide-by-ten step used by the core.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int          DIGITS_MAX = 20;
   localparam int          CNT_W      = $clog2(DIGITS_MAX + 1);
   localparam logic [7:0]  CHAR_MINUS = 8'h2D;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;

   // Entry {quotient, remainder} of an 8-bit value {rem, nibble} divided by ten.
   // Only values below 160 occur; the upper entries are never read.
   typedef logic [7:0] div_table_type [0:255];

   typedef struct packed {
      logic [31:0] quot;
      logic [3:0]  rem;
   } div_result_type;

   function automatic div_table_type build_div10_table();
      div_table_type tbl;
      logic [4:0]    q;
      logic [3:0]    r;
      q = '0;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = {q[3:0], r};
         if (r == 4'd9) begin
            r = '0;
            q = q + 5'd1;
         end else begin
            r = r + 4'd1;
         end
      end
      return tbl;
   endfunction

   localparam div_table_type DIV10_TABLE = build_div10_table();

   // Long division of a 32-bit word by ten, one nibble per table lookup,
   // carrying the remainder from the more significant word.
   function automatic div_result_type div10_word(input logic [3:0]  rem_in,
                                                 input logic [31:0] word);
      div_result_type res;
      logic [3:0]     r;
      logic [7:0]     entry;
      r = rem_in;
      res.quot = '0;
      for (int i = 7; i >= 0; i--) begin
         entry = DIV10_TABLE[{r, word[i*4 +: 4]}];
         res.quot[i*4 +: 4] = entry[7:4];
         r = entry[3:0];
      end
      res.rem = r;
      return res;
   endfunction

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed 64-bit integer to decimal ASCII
// Converts one value per request into its decimal characters, sign first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The magnitude is
// divided by ten repeatedly through one shared 32-bit divide unit: a digit
// takes a high step and then a low step while the remaining magnitude needs
// more than 32 bits and only a low step after that. Digits are stacked, then
// sent most significant first, one character per cycle on rsp_valid, with the
// minus sign ahead of them for a negative value and rsp_last on the final
// character. The receiver cannot stall: each character is shown for exactly
// one cycle.
module signed_int_to_decimal_ascii_core
   import sitda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_number,
   output logic        rsp_valid,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_HIGH = 5'b00010,
      ST_LOW  = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [63:0]      mag_ff, mag_in;
   logic [3:0]       rem_ff, rem_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       digit_ff [0:DIGITS_MAX-1];

   div_result_type   div_res;
   logic [31:0]      div_word;
   logic [3:0]       div_rem;
   logic [63:0]      abs_number;
   logic [63:0]      mag_next;
   logic [CNT_W-1:0] rd_idx;

   assign abs_number = req_number[63] ? (~req_number + 64'd1) : req_number;

   // Shared divide unit: upper word in the high step, lower word otherwise.
   assign div_word = (state_ff == ST_HIGH) ? mag_ff[63:32] : mag_ff[31:0];
   assign div_rem  = (state_ff == ST_HIGH) ? 4'd0 : rem_ff;
   assign div_res  = div10_word(div_rem, div_word);
   assign mag_next = {mag_ff[63:32], div_res.quot};

   assign rd_idx   = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = req_number[63];
               mag_in   = abs_number;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = (abs_number[63:32] != 32'd0) ? ST_HIGH : ST_LOW;
            end
         end
         ST_HIGH: begin
            mag_in[63:32] = div_res.quot;
            rem_in        = div_res.rem;
            state_in      = ST_LOW;
         end
         ST_LOW: begin
            mag_in = mag_next;
            rem_in = '0;
            cnt_in = cnt_ff + CNT_W'(1);
            if (mag_next == 64'd0 || cnt_ff == CNT_W'(DIGITS_MAX - 1)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else if (mag_next[63:32] != 32'd0) begin
               state_in = ST_HIGH;
            end else begin
               state_in = ST_LOW;
            end
         end
         ST_SIGN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cnt_in = rd_idx;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Push each remainder onto the digit stack.
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOW) begin
         digit_ff[cnt_ff] <= div_res.rem;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_character = (state_ff == ST_SIGN) ? CHAR_MINUS
                                                : (CHAR_ZERO + {4'd0, digit_ff[rd_idx]});
   assign rsp_last      = (state_ff == ST_EMIT) && (cnt_ff == CNT_W'(1));

endmodule
